FILE: hw/rtl/rlk_pkg.sv
// rlk_pkg: shared types and constants of the resistor ladder keypad debouncer
// used by rlk_front, rlk_back and the core; no dependencies
`default_nettype none

package rlk_pkg;

	localparam int CODE_W    = 3;
	localparam int CNT_W     = 8;
	localparam int CFG_IDX_W = 3;
	localparam int THR_W     = 16;
	localparam int MAX_KEYS  = 7;

	localparam logic ACT_SCAN   = 1'b0;
	localparam logic ACT_REPEAT = 1'b1;

	localparam logic [CODE_W-1:0] KEY_NONE = '0;
	localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

	localparam logic [CNT_W-1:0] EDGE_RESET = 8'd5;

	// threshold reset values, key 1 at index 0
	localparam logic [MAX_KEYS-1:0][THR_W-1:0] THR_RESET = {
		16'd1000, 16'd1000, 16'd800, 16'd600, 16'd400, 16'd200, 16'd50
	};

	typedef struct packed {
		logic              rep;
		logic [CODE_W-1:0] code;
	} scan_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rlk_fifo.sv
// rlk_fifo: small register queue with push/full and pop/empty sides
// generic width and depth; no dependencies
`default_nettype none

module rlk_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/rlk_front.sv
// rlk_front: accepts words and decodes the ladder sample into a key code
// depends on rlk_pkg
`default_nettype none

module rlk_front
	import rlk_pkg::*;
#(
	parameter int SAMPLE_BITS = 10,
	parameter int KEY_COUNT   = 5
) (
	input  wire logic                                 push,
	input  wire logic                                 action,
	input  wire logic [SAMPLE_BITS-1:0]               adc_sample,
	input  wire logic [KEY_COUNT-1:0][SAMPLE_BITS-1:0] thr,
	output logic                                      full,
	input  wire logic                                 q_full,
	output logic                                      q_push,
	output scan_t                                     q_item
);

	logic [CODE_W-1:0] code;

	// first threshold the sample lies below wins
	always_comb begin
		code = KEY_NONE;
		for (int k = KEY_COUNT - 1; k >= 0; k--) begin
			if (adc_sample < thr[k]) begin
				code = CODE_W'(k + 1);
			end
		end
	end

	assign full        = q_full;
	assign q_push      = push && !q_full;
	assign q_item.rep  = (action == ACT_REPEAT);
	assign q_item.code = code;

endmodule

`default_nettype wire

FILE: hw/rtl/rlk_back.sv
// rlk_back: debounce counter and press event generation
// depends on rlk_pkg
`default_nettype none

module rlk_back
	import rlk_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [CNT_W-1:0] debounce_edge,
	input  wire logic             q_empty,
	input  wire scan_t            q_item,
	output logic                  q_pop,
	input  wire logic             out_full,
	output logic                  out_push,
	output logic     [CODE_W-1:0] out_code
);

	logic [CODE_W-1:0] last_key_q;
	logic [CNT_W-1:0]  count_q;
	logic [CODE_W-1:0] key_d;
	logic [CNT_W-1:0]  count_d;
	logic              emit;

	assign q_pop    = !q_empty && !out_full;
	assign out_push = q_pop && emit;
	assign out_code = q_item.code;

	always_comb begin
		key_d   = last_key_q;
		count_d = count_q;
		emit    = 1'b0;
		if (q_item.rep) begin
			if (count_q != '0) begin
				count_d = count_q - 1'b1;
			end
		end else if (q_item.code == KEY_NONE) begin
			if (last_key_q != KEY_NONE) begin
				if (count_q != '0) begin
					count_d = count_q - 1'b1;
				end else begin
					key_d = KEY_NONE;
				end
			end
		end else if (q_item.code != last_key_q) begin
			key_d   = q_item.code;
			count_d = '0;
		end else if (count_q < debounce_edge) begin
			count_d = count_q + 1'b1;
		end else if (count_q == debounce_edge) begin
			emit = 1'b1;
			if (count_q != CNT_MAX) begin
				count_d = count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_key_q <= KEY_NONE;
			count_q    <= '0;
		end else if (q_pop) begin
			last_key_q <= key_d;
			count_q    <= count_d;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/resistor_ladder_keypad_debouncer_core.sv
// resistor_ladder_keypad_debouncer_core: top level of the keypad debouncer
// depends on rlk_pkg, rlk_fifo, rlk_front, rlk_back
//
// usage
// input queue side: a word (action, adc_sample) is taken when push is high
// and full is low; action 0 is a scan with a ladder sample, 1 a repeat request
// result queue side: key_code of the oldest press event is valid while empty
// is low and leaves on a cycle with pop high
// config side: cfg_index/cfg_data written when cfg_valid is high; cfg_ready
// is always high; indexes 0..KEY_COUNT-1 are thresholds, KEY_COUNT the edge
// one word per cycle sustained while the result queue has room; a press event
// reaches the result side through the decode queue and the counter update
// a two-entry queue sits between decode and counter, another on the result
// side; when pop stays low the result queue fills, the counter stops, and
// full rises once the decode queue is also full
// reset: queues empty, no key held, count zero, thresholds 50/200/400/600/800,
// edge 5
`default_nettype none

module resistor_ladder_keypad_debouncer_core
	import rlk_pkg::*;
#(
	parameter int SAMPLE_BITS = 10,
	parameter int KEY_COUNT   = 5
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	output logic                        full,
	input  wire logic                   action,
	input  wire logic [SAMPLE_BITS-1:0] adc_sample,
	output logic                        empty,
	input  wire logic                   pop,
	output logic      [CODE_W-1:0]      key_code,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [((SAMPLE_BITS > CNT_W) ? SAMPLE_BITS : CNT_W)-1:0] cfg_data
);

	logic [KEY_COUNT-1:0][SAMPLE_BITS-1:0] thr_q;
	logic [CNT_W-1:0]                      edge_q;

	logic        mid_push;
	logic        mid_full;
	logic        mid_pop;
	logic        mid_empty;
	scan_t       mid_wdata;
	scan_t       mid_rdata;
	logic        out_push;
	logic        out_full;
	logic [CODE_W-1:0] out_code;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < KEY_COUNT; k++) begin
				thr_q[k] <= THR_RESET[k][SAMPLE_BITS-1:0];
			end
			edge_q <= EDGE_RESET;
		end else if (cfg_valid) begin
			for (int k = 0; k < KEY_COUNT; k++) begin
				if (cfg_index == CFG_IDX_W'(k)) begin
					thr_q[k] <= cfg_data[SAMPLE_BITS-1:0];
				end
			end
			if (cfg_index == CFG_IDX_W'(KEY_COUNT)) begin
				edge_q <= cfg_data[CNT_W-1:0];
			end
		end
	end

	rlk_front #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.KEY_COUNT  (KEY_COUNT)
	) u_front (
		.push      (push),
		.action    (action),
		.adc_sample(adc_sample),
		.thr       (thr_q),
		.full      (full),
		.q_full    (mid_full),
		.q_push    (mid_push),
		.q_item    (mid_wdata)
	);

	rlk_fifo #(
		.WIDTH($bits(scan_t)),
		.DEPTH(2)
	) u_mid_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (mid_push),
		.wdata (mid_wdata),
		.full  (mid_full),
		.pop   (mid_pop),
		.rdata (mid_rdata),
		.empty (mid_empty)
	);

	rlk_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.debounce_edge(edge_q),
		.q_empty      (mid_empty),
		.q_item       (mid_rdata),
		.q_pop        (mid_pop),
		.out_full     (out_full),
		.out_push     (out_push),
		.out_code     (out_code)
	);

	rlk_fifo #(
		.WIDTH(CODE_W),
		.DEPTH(2)
	) u_out_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.wdata (out_code),
		.full  (out_full),
		.pop   (pop),
		.rdata (key_code),
		.empty (empty)
	);

endmodule

`default_nettype wire
